// ===== rtl/core/qrs_pkg.sv =====
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ROOT_WIDTH     = 34;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_A_ZERO  = 1'b1;

   localparam logic [1:0] NUM_REAL_NONE = 2'd0;
   localparam logic [1:0] NUM_REAL_ONE  = 2'd1;
   localparam logic [1:0] NUM_REAL_TWO  = 2'd2;

endpackage

// ===== rtl/core/qrs_if.sv =====
interface qrs_if #(
   parameter int W = 8
);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/qrs_sqrt_stage.sv =====
// One pipeline stage of the restoring square root: resolves one root bit.
module qrs_sqrt_stage #(
   parameter int RAD_W = 34,
   parameter int RES_W = 17,
   parameter int STEP  = 0
) (
   input  logic [RAD_W-1:0] rem_i,
   input  logic [RES_W-1:0] res_i,
   output logic [RAD_W-1:0] rem_o,
   output logic [RES_W-1:0] res_o
);
   import qrs_pkg::*;

   localparam int SH = 2 * (RES_W - 1 - STEP);

   logic [RAD_W+1:0] trial;
   logic [RAD_W+1:0] part;

   // try the next root bit against the remaining radicand
   always_comb begin
      part  = {2'b00, rem_i} >> SH;
      trial = {{(RAD_W+2-RES_W-2){1'b0}}, res_i, 2'b01};
      if (part >= trial) begin
         rem_o = rem_i - RAD_W'(trial << SH);
         res_o = {res_i[RES_W-2:0], 1'b1};
      end else begin
         rem_o = rem_i;
         res_o = {res_i[RES_W-2:0], 1'b0};
      end
   end
endmodule

// ===== rtl/core/qrs_div_stage.sv =====
// One pipeline stage of the restoring divider: resolves one quotient bit.
module qrs_div_stage #(
   parameter int NUM_W = 56,
   parameter int DEN_W = 18,
   parameter int STEP  = 0
) (
   input  logic [NUM_W-1:0] rem_i,
   input  logic [DEN_W-1:0] den_i,
   input  logic [NUM_W-1:0] quo_i,
   output logic [NUM_W-1:0] rem_o,
   output logic [NUM_W-1:0] quo_o
);
   import qrs_pkg::*;

   localparam int SH = NUM_W - 1 - STEP;

   logic [NUM_W+DEN_W-1:0] shd;

   // subtract the shifted divisor when it fits
   always_comb begin
      shd   = {{NUM_W{1'b0}}, den_i} << SH;
      quo_o = quo_i;
      rem_o = rem_i;
      if ({{DEN_W{1'b0}}, rem_i} >= shd) begin
         rem_o      = rem_i - NUM_W'(shd);
         quo_o[SH]  = 1'b1;
      end
   end
endmodule

// ===== rtl/core/quadratic_root_solver_unit.sv =====
// Channel | Direction | Payload
// req     | in        | a_coef, b_coef, c_coef (signed COEF_WIDTH)
// rsp     | out       | status, num_real, root1_re, root2_re, root_im
//
// Fully pipelined: one equation per cycle while rsp does not stall; the depth is
// set by the sqrt and divide stage chains, one root/quotient bit per register
// stage.
// Synchronous reset clears only the valid bits. A stall on rsp freezes every
// stage at once; req is taken whenever the last stage is empty or moving.
module quadratic_root_solver_unit #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   qrs_if.sink   req,
   qrs_if.source rsp
);
   import qrs_pkg::*;

   localparam int CW    = COEF_WIDTH;
   localparam int DW    = 2 * CW + 3;             // |D| fits
   localparam int SW    = (DW + 1) / 2;           // root width
   localparam int NW    = CW + 2 + FRAC_BITS;     // |numerator| scaled
   localparam int DNW   = CW + 2;                 // |2a|
   localparam int NS    = 4 + SW + NW;            // stage count (pipe depth)
   localparam int RW    = ROOT_WIDTH;
   localparam logic [NW:0] RMAX = (NW+1)'((64'd1 << (RW-1)) - 1);

   // per-stage control and payload
   logic [NS-1:0] vld_ff;
   logic          adv;
   assign adv       = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = adv;

   // stage 0: products
   logic signed [CW-1:0] a_in, b_in, c_in;
   assign a_in = req.data[3*CW-1:2*CW];
   assign b_in = req.data[2*CW-1:CW];
   assign c_in = req.data[CW-1:0];

   logic signed [DW-1:0] bb_ff, ac4_ff;
   logic signed [CW-1:0] a0_ff, b0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         bb_ff  <= DW'(b_in) * DW'(b_in);
         ac4_ff <= (DW'(a_in) * DW'(c_in)) <<< 2;
         a0_ff  <= a_in;
         b0_ff  <= b_in;
      end
   end

   // stage 1: discriminant
   logic signed [DW-1:0] d1;
   logic [DW:0] dabs;
   assign d1   = bb_ff - ac4_ff;
   assign dabs = d1[DW-1] ? (DW+1)'(-d1) : (DW+1)'(d1);

   // sqrt pipeline
   logic [2*SW-1:0] srem_ff [SW+1];
   logic [SW-1:0]   sres_ff [SW+1];
   logic signed [CW-1:0] sa_ff [SW+1];
   logic signed [CW-1:0] sb_ff [SW+1];
   logic [1:0]      snr_ff [SW+1];
   logic            sneg_ff [SW+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         srem_ff[0] <= (2*SW)'(dabs);
         sres_ff[0] <= '0;
         sa_ff[0]   <= a0_ff;
         sb_ff[0]   <= b0_ff;
         sneg_ff[0] <= d1[DW-1];
         snr_ff[0]  <= d1[DW-1] ? NUM_REAL_NONE :
                       (d1 == '0) ? NUM_REAL_ONE : NUM_REAL_TWO;
      end
   end

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      logic [2*SW-1:0] rem_n;
      logic [SW-1:0]   res_n;
      qrs_sqrt_stage #(.RAD_W(2*SW), .RES_W(SW), .STEP(i)) u_st (
         .rem_i(srem_ff[i]), .res_i(sres_ff[i]), .rem_o(rem_n), .res_o(res_n)
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            srem_ff[i+1] <= rem_n;
            sres_ff[i+1] <= res_n;
            sa_ff[i+1]   <= sa_ff[i];
            sb_ff[i+1]   <= sb_ff[i];
            snr_ff[i+1]  <= snr_ff[i];
            sneg_ff[i+1] <= sneg_ff[i];
         end
      end
   end

   // numerators: lane 0 root1, lane 1 root2, lane 2 imaginary
   logic signed [CW+1:0] s_s, nb_s, a_s;
   logic signed [CW+1:0] num [3];
   logic signed [DNW:0]  den_s;
   assign s_s   = $signed({1'b0, sres_ff[SW][CW:0]});
   assign nb_s  = -(CW+2)'(sb_ff[SW]);
   assign a_s   = (CW+2)'(sa_ff[SW]);
   assign den_s = (DNW+1)'(a_s) <<< 1;
   always_comb begin
      if (sneg_ff[SW]) begin
         num[0] = nb_s; num[1] = nb_s; num[2] = s_s;
      end else begin
         num[0] = nb_s + s_s; num[1] = nb_s - s_s; num[2] = '0;
      end
   end

   logic [NW-1:0]  drem_ff [3][NW+1];
   logic [NW-1:0]  dquo_ff [3][NW+1];
   logic           dng_ff  [3][NW+1];
   logic [DNW-1:0] dden_ff [NW+1];
   logic           dz_ff   [NW+1];
   logic [1:0]     dnr_ff  [NW+1];

   for (genvar k = 0; k < 3; k++) begin : g_lane_in
      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[k][0] <= NW'(num[k][CW+1] ? -num[k] : num[k]) << FRAC_BITS;
            dquo_ff[k][0] <= '0;
            dng_ff[k][0]  <= num[k][CW+1] ^ den_s[DNW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dden_ff[0] <= den_s[DNW] ? DNW'(-den_s) : DNW'(den_s);
         dz_ff[0]   <= (sa_ff[SW] == '0);
         dnr_ff[0]  <= snr_ff[SW];
      end
   end

   for (genvar i = 0; i < NW; i++) begin : g_div
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [NW-1:0] rem_n, quo_n;
         qrs_div_stage #(.NUM_W(NW), .DEN_W(DNW), .STEP(i)) u_st (
            .rem_i(drem_ff[k][i]), .den_i(dden_ff[i]), .quo_i(dquo_ff[k][i]),
            .rem_o(rem_n), .quo_o(quo_n)
         );
         always_ff @(posedge clock) begin
            if (adv) begin
               drem_ff[k][i+1] <= rem_n;
               dquo_ff[k][i+1] <= quo_n;
               dng_ff[k][i+1]  <= dng_ff[k][i];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dden_ff[i+1] <= dden_ff[i];
            dz_ff[i+1]   <= dz_ff[i];
            dnr_ff[i+1]  <= dnr_ff[i];
         end
      end
   end

   // sign, saturate and register output
   logic [RW-1:0] root_ff [3];
   logic          st_ff;
   logic [1:0]    nr_ff;
   logic [RW-1:0] sat [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [NW:0] mag;
         mag = {1'b0, dquo_ff[k][NW]};
         if (dz_ff[NW])
            sat[k] = '0;
         else if (!dng_ff[k][NW])
            sat[k] = (mag > RMAX) ? RW'(RMAX) : RW'(mag);
         else
            sat[k] = (mag > RMAX) ? RW'(-RMAX - 1) : RW'(-mag);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) root_ff[k] <= sat[k];
         st_ff <= dz_ff[NW] ? STATUS_A_ZERO : STATUS_OK;
         nr_ff <= dz_ff[NW] ? NUM_REAL_NONE : dnr_ff[NW];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= {vld_ff[NS-2:0], req.valid};
   end

   assign rsp.valid = vld_ff[NS-1];
   assign rsp.data  = {st_ff, nr_ff, root_ff[0], root_ff[1], root_ff[2]};
endmodule
